// ----- sv/btwa_pkg.sv -----
// shared widths, constants and register codes of the barometer trend averager
// no dependencies
`default_nettype none
package btwa_pkg;

  localparam int P_W        = 28;   // ring pressure, Pa Q.11
  localparam int T_W        = 26;   // ring temperature, degC Q.18
  localparam int TIME_W     = 32;
  localparam int PKT_W      = 48;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_P_W    = 17;
  localparam int OUT_T_W    = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 23;
  localparam int THR_W      = 23;
  localparam int GAIN_W     = 17;
  localparam int MINS_W     = 4;
  localparam int DIV_DW     = 52;   // shared divider dividend / quotient
  localparam int DIV_VW     = 56;   // shared divider divisor / remainder

  localparam logic signed [30:0] P_SCALE  = 31'sd625;
  localparam logic signed [30:0] P_OFFSET = 31'sd143360000;
  localparam logic signed [30:0] P_MIN    = 31'sd61440000;
  localparam logic signed [30:0] P_MAX    = 31'sd225280000;
  localparam logic signed [27:0] T_SCALE  = 28'sd65;
  localparam logic signed [27:0] T_OFFSET = 28'sd6553600;
  localparam logic signed [27:0] T_MIN    = -28'sd10485760;
  localparam logic signed [27:0] T_MAX    = 28'sd22282240;
  localparam logic [OUT_P_W-1:0] P_OUT_MAX = 17'd131071;
  localparam logic signed [7:0]  CENTI     = 8'sd100;

  localparam logic [THR_W-1:0]  THR_RESET  = 23'd32768;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd19661;
  localparam logic [GAIN_W-1:0] CAP_RESET  = 17'd32768;
  localparam logic [MINS_W-1:0] MINS_RESET = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 8'd0,
    CFG_GAIN      = 8'd1,
    CFG_CAP       = 8'd2,
    CFG_MIN_SMP   = 8'd3
  } cfg_idx_t;

endpackage
`default_nettype wire

// ----- sv/baro_trend_weighted_averager_top.sv -----
// barometer trend-weighted averager: packet check, sample ring, batch statistics
// depends on btwa_pkg
`default_nettype none
// Takes one barometer FIFO packet per item (tuser = packet present), checks and
// converts it to fixed point, and stores kept samples with their timestamp in a
// ring of RING_DEPTH entries. An item with tlast closes a batch and yields one
// result item: held pressure in Pa, held temperature in 0.01 degC and tuser set
// when a new trend average was computed. Items are handled one at a time; in_tready
// is high only while the sequencer is idle. An item with a packet passes through a
// conversion and a store state. A batch end that runs the average reads the held
// samples, divides for the mean and, unless the slope stays under the threshold,
// for the bias factor, divides for the temperature and then waits on out_tready:
// the ring is read one entry at a time through a read and an accumulate state, and
// a single restoring divider, one quotient bit per cycle, serves the mean, the bias
// factor and the temperature. The ring is not cleared at reset; only written
// entries are read.
module baro_trend_weighted_averager_top #(
  parameter int RING_DEPTH = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // [47:0] packet_bytes, [79:48] timestamp_ms
  input  wire logic [btwa_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] has_sample
  input  wire logic                             in_tuser,
  input  wire logic                             in_tlast,   // end_of_batch
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // [16:0] pressure_pa, [31:17] temperature_centideg
  output      logic [btwa_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] updated
  output      logic                             out_tuser,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [btwa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [btwa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import btwa_pkg::*;

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int PSW   = P_W + AW + 1;       // pressure sum
  localparam int TSW   = T_W + AW + 1;       // temperature sum, signed
  localparam int XW    = TSW + 7;            // temperature sum times 100
  localparam int DCW   = $clog2(DIV_DW);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(RING_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CONV, ST_STORE, ST_BATCH, ST_RD, ST_ACC, ST_MEAN, ST_DIV,
    ST_TREND1, ST_TREND2, ST_BIAS, ST_FIN, ST_FIN2, ST_TPREP, ST_TDONE,
    ST_MOVE, ST_OUT
  } state_t;

  // sample ring
  logic [P_W-1:0]    ring_p [RING_DEPTH];
  logic [T_W-1:0]    ring_t [RING_DEPTH];
  logic [TIME_W-1:0] ring_tm[RING_DEPTH];
  logic [P_W-1:0]    rd_p_r;
  logic [T_W-1:0]    rd_t_r;
  logic [TIME_W-1:0] rd_tm_r;

  state_t state_r, div_ret_r;

  // configuration
  logic [THR_W-1:0]  thr_r;
  logic [GAIN_W-1:0] gain_r, cap_r;
  logic [MINS_W-1:0] mins_r;

  // latched item
  logic [PKT_W-1:0]  pkt_r;
  logic [TIME_W-1:0] ts_r;
  logic              has_r, eob_r;

  // conversion
  logic signed [30:0] pq_r;
  logic signed [27:0] tq_r;
  logic               keep_r;

  // ring pointers
  logic [AW-1:0] slot_r, idx_r;
  logic [CW-1:0] fill_r, n_r, cnt_r;

  // scan results
  logic [PSW-1:0]        psum_r;
  logic signed [TSW-1:0] tsum_r;
  logic [P_W-1:0]        pmin_r, pmax_r, old_p_r, new_p_r;
  logic [T_W-1:0]        new_t_r;
  logic [TIME_W-1:0]     old_tm_r, new_tm_r;

  // trend
  logic [P_W-1:0]        mean_r, target_r;
  logic signed [28:0]    d_r;
  logic [32:0]           mag_r;
  logic [TIME_W-1:0]     span_r;
  logic [54:0]           lim_r;
  logic [GAIN_W-1:0]     bias_r;
  logic signed [46:0]    prod_r;
  logic signed [XW-1:0]  x_r;
  logic                  neg_r;

  // shared divider
  logic [DIV_DW-1:0] div_q_r;
  logic [DIV_VW-1:0] div_rem_r, div_d_r;
  logic [DCW-1:0]    div_cnt_r;

  // results
  logic [OUT_P_W-1:0] held_p_r;
  logic [OUT_T_W-1:0] held_t_r;
  logic               upd_r;

  // combinational helpers
  logic signed [19:0] rp_w, rt_w;
  logic               all_ff_w, all_00_w;
  logic [DIV_VW:0]    trial_w;
  logic               ge_w;
  logic [AW:0]        oldest_w;
  logic [MINS_W-1:0]  need_w;
  logic [THR_W-1:0]   thr_eff_w;
  logic signed [28:0] d_w, diff_w;
  logic [27:0]        dabs_w;
  logic [TIME_W-1:0]  span_w;
  logic signed [47:0] fin_w;
  logic [XW-1:0]      ax_w;
  logic [AW-1:0]      idx_inc_w;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [P_W-1:0]     wr_p;
  logic [T_W-1:0]     wr_t;
  logic [TIME_W-1:0]  wr_tm;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {held_t_r, held_p_r};
  assign out_tuser  = upd_r;
  assign cfg_ready  = 1'b1;

  assign rp_w     = $signed({pkt_r[19:16], pkt_r[15:0]});
  assign rt_w     = $signed({pkt_r[43:40], pkt_r[39:24]});
  assign all_ff_w = &pkt_r;
  assign all_00_w = ~|pkt_r;

  assign trial_w = {div_rem_r, div_q_r[DIV_DW-1]};
  assign ge_w    = (trial_w >= {1'b0, div_d_r});

  // oldest held slot, modulo ring depth
  always_comb begin
    oldest_w = {1'b0, slot_r} + DEPTH_X - (AW + 1)'(fill_r);
    if (oldest_w >= DEPTH_X) oldest_w = oldest_w - DEPTH_X;
  end

  assign idx_inc_w = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
  assign need_w    = (mins_r == '0) ? MINS_W'(1) : mins_r;
  assign thr_eff_w = (thr_r == '0) ? THR_W'(1) : thr_r;
  assign d_w       = $signed({1'b0, new_p_r}) - $signed({1'b0, old_p_r});
  assign dabs_w    = d_w[28] ? 28'(-d_w) : 28'(d_w);
  assign span_w    = new_tm_r - old_tm_r;
  assign diff_w    = $signed({1'b0, target_r}) - $signed({1'b0, mean_r});
  assign fin_w     = $signed({4'b0, mean_r, 16'b0}) + 48'(prod_r);
  assign ax_w      = x_r[XW-1] ? XW'(-x_r) : XW'(x_r);

  // ring write port: sample store or newest-to-front move
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_p    = pq_r[P_W-1:0];
    wr_t    = tq_r[T_W-1:0];
    wr_tm   = ts_r;
    if (state_r == ST_STORE) begin
      wr_en = keep_r && pq_r >= P_MIN && pq_r <= P_MAX && tq_r >= T_MIN && tq_r <= T_MAX;
    end else if (state_r == ST_MOVE) begin
      wr_en   = (n_r > CW'(1));
      wr_addr = '0;
      wr_p    = new_p_r;
      wr_t    = new_t_r;
      wr_tm   = new_tm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_p[wr_addr]  <= wr_p;
      ring_t[wr_addr]  <= wr_t;
      ring_tm[wr_addr] <= wr_tm;
    end
    rd_p_r  <= ring_p[idx_r];
    rd_t_r  <= ring_t[idx_r];
    rd_tm_r <= ring_tm[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_ret_r <= ST_IDLE;
      thr_r     <= THR_RESET;
      gain_r    <= GAIN_RESET;
      cap_r     <= CAP_RESET;
      mins_r    <= MINS_RESET;
      slot_r    <= '0;
      fill_r    <= '0;
      held_p_r  <= '0;
      held_t_r  <= '0;
      upd_r     <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
          CFG_GAIN:      gain_r <= cfg_data[GAIN_W-1:0];
          CFG_CAP:       cap_r  <= cfg_data[GAIN_W-1:0];
          CFG_MIN_SMP:   mins_r <= cfg_data[MINS_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            pkt_r <= in_tdata[PKT_W-1:0];
            ts_r  <= in_tdata[IN_DATA_W-1:PKT_W];
            has_r <= in_tuser;
            eob_r <= in_tlast;
            if (in_tuser)      state_r <= ST_CONV;
            else if (in_tlast) state_r <= ST_BATCH;
          end
        end
        ST_CONV: begin
          pq_r    <= 31'(rp_w * P_SCALE) + P_OFFSET;
          tq_r    <= 28'(rt_w * T_SCALE) + T_OFFSET;
          keep_r  <= has_r && !all_ff_w && !all_00_w && !(rp_w == '0 && rt_w == '0);
          state_r <= ST_STORE;
        end
        ST_STORE: begin
          if (wr_en) begin
            slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
            if (fill_r < CW'(RING_DEPTH)) fill_r <= fill_r + 1'b1;
          end
          state_r <= eob_r ? ST_BATCH : ST_IDLE;
        end
        ST_BATCH: begin
          n_r    <= fill_r;
          cnt_r  <= '0;
          idx_r  <= oldest_w[AW-1:0];
          psum_r <= '0;
          tsum_r <= '0;
          pmin_r <= '1;
          pmax_r <= '0;
          if (fill_r == '0 || 8'(fill_r) < 8'(need_w)) begin
            upd_r   <= 1'b0;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_RD;
          end
        end
        ST_RD: state_r <= ST_ACC;   // ring read in flight
        ST_ACC: begin
          psum_r <= psum_r + PSW'(rd_p_r);
          tsum_r <= tsum_r + {{(AW + 1){rd_t_r[T_W-1]}}, rd_t_r};
          if (rd_p_r < pmin_r) pmin_r <= rd_p_r;
          if (rd_p_r > pmax_r) pmax_r <= rd_p_r;
          if (cnt_r == '0) begin
            old_p_r  <= rd_p_r;
            old_tm_r <= rd_tm_r;
          end
          if (cnt_r == n_r - 1'b1) begin
            new_p_r  <= rd_p_r;
            new_t_r  <= rd_t_r;
            new_tm_r <= rd_tm_r;
            state_r  <= ST_MEAN;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            idx_r   <= idx_inc_w;
            state_r <= ST_RD;
          end
        end
        ST_MEAN: begin
          div_q_r   <= DIV_DW'(psum_r);
          div_rem_r <= '0;
          div_d_r   <= DIV_VW'(n_r);
          div_cnt_r <= '0;
          div_ret_r <= ST_TREND1;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          // one quotient bit per cycle
          div_rem_r <= ge_w ? DIV_VW'(trial_w - {1'b0, div_d_r}) : DIV_VW'(trial_w);
          div_q_r   <= {div_q_r[DIV_DW-2:0], ge_w};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DCW'(DIV_DW - 1)) state_r <= div_ret_r;
        end
        ST_TREND1: begin
          mean_r  <= div_q_r[P_W-1:0];
          d_r     <= d_w;
          mag_r   <= {dabs_w, 5'b0};
          span_r  <= span_w;
          lim_r   <= thr_eff_w * span_w;
          state_r <= ST_TREND2;
        end
        ST_TREND2: begin
          target_r <= mean_r;
          bias_r   <= '0;
          if (span_r != '0 && 55'(mag_r) > lim_r) begin
            div_q_r   <= DIV_DW'(mag_r) * DIV_DW'(gain_r);
            div_rem_r <= '0;
            div_d_r   <= DIV_VW'(lim_r);
            div_cnt_r <= '0;
            div_ret_r <= ST_BIAS;
            state_r   <= ST_DIV;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_BIAS: begin
          bias_r   <= (div_q_r > DIV_DW'(cap_r)) ? cap_r : div_q_r[GAIN_W-1:0];
          target_r <= d_r[28] ? pmin_r : pmax_r;
          state_r  <= ST_FIN;
        end
        ST_FIN: begin
          prod_r  <= 47'(diff_w) * 47'($signed({1'b0, bias_r}));
          x_r     <= XW'(tsum_r) * XW'(CENTI);
          state_r <= ST_FIN2;
        end
        ST_FIN2: begin
          if (fin_w[47])                           held_p_r <= '0;
          else if (fin_w[46:27] > 20'(P_OUT_MAX))  held_p_r <= P_OUT_MAX;
          else                                     held_p_r <= fin_w[27+OUT_P_W-1:27];
          state_r <= ST_TPREP;
        end
        ST_TPREP: begin
          neg_r     <= x_r[XW-1];
          div_q_r   <= DIV_DW'(ax_w >> 18);
          div_rem_r <= '0;
          div_d_r   <= DIV_VW'(n_r);
          div_cnt_r <= '0;
          div_ret_r <= ST_TDONE;
          state_r   <= ST_DIV;
        end
        ST_TDONE: begin
          held_t_r <= neg_r ? OUT_T_W'(-div_q_r[OUT_T_W-1:0]) : div_q_r[OUT_T_W-1:0];
          state_r  <= ST_MOVE;
        end
        ST_MOVE: begin
          if (n_r > CW'(1)) begin
            slot_r <= AW'(1);
            fill_r <= CW'(1);
          end
          upd_r   <= 1'b1;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_tready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ring occupancy never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(RING_DEPTH) && slot_r <= LAST_SLOT)
    else $error("ring pointer out of range");

  // input and result sides are never open together
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // a fresh trend average leaves exactly the newest sample held
  a_upd_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> fill_r == CW'(1))
    else $error("ring not collapsed after trend average");

  // divider only finishes into a valid continuation
  a_div_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_ret_r == ST_TREND1 || div_ret_r == ST_BIAS ||
                             div_ret_r == ST_TDONE))
    else $error("divider return state corrupt");

endmodule
`default_nettype wire
